// File: design/tlnef_pkg.sv
// ----------------------------------------------------------------------------
// tlnef_pkg
// Shared types, character codes, register map and control store for the
// line-numbering and escape display filter.
// ----------------------------------------------------------------------------
package tlnef_pkg;

   localparam int CSR_AW       = 5;
   localparam int COUNT_DIGITS = 6;

   localparam logic [7:0] CHR_TAB    = 8'h09;
   localparam logic [7:0] CHR_NL     = 8'h0a;
   localparam logic [7:0] CHR_SPACE  = 8'h20;
   localparam logic [7:0] CHR_DOLLAR = 8'h24;
   localparam logic [7:0] CHR_DASH   = 8'h2d;
   localparam logic [7:0] CHR_ZERO   = 8'h30;
   localparam logic [7:0] CHR_QMARK  = 8'h3f;
   localparam logic [7:0] CHR_I      = 8'h49;
   localparam logic [7:0] CHR_M      = 8'h4d;
   localparam logic [7:0] CHR_CARET  = 8'h5e;
   localparam logic [7:0] CHR_DEL    = 8'h7f;
   localparam logic [7:0] CARET_BIAS = 8'h40;
   localparam logic [7:0] CTRL_LIMIT = 8'h20;

   localparam logic [2:0] REG_SQUEEZE_BLANK    = 3'd0;
   localparam logic [2:0] REG_NUMBER_ALL       = 3'd1;
   localparam logic [2:0] REG_NUMBER_NONBLANK  = 3'd2;
   localparam logic [2:0] REG_SHOW_ENDS        = 3'd3;
   localparam logic [2:0] REG_SHOW_TABS        = 3'd4;
   localparam logic [2:0] REG_SHOW_NONPRINTING = 3'd5;

   typedef struct packed {
      logic squeeze_blank;
      logic number_all;
      logic number_nonblank;
      logic show_ends;
      logic show_tabs;
      logic show_nonprinting;
   } cfg_type;

   typedef enum logic [1:0] {
      SRC_NONE,
      SRC_DIGIT,
      SRC_TAB,
      SRC_BODY
   } src_type;

   typedef enum logic [1:0] {
      COND_ITEM,
      COND_NONE,
      COND_DIGIT_LOOP,
      COND_BODY_LOOP
   } cond_type;

   typedef logic [1:0] uaddr_type;

   localparam uaddr_type UA_FETCH = 2'd0;
   localparam uaddr_type UA_NUM   = 2'd1;
   localparam uaddr_type UA_TAB   = 2'd2;
   localparam uaddr_type UA_BODY  = 2'd3;

   // alt: taken while a loop runs, or for an unnumbered item at fetch
   typedef struct packed {
      src_type   src;
      cond_type  cond;
      uaddr_type alt;
      uaddr_type next;
   } ucode_type;

   localparam ucode_type UCODE [4] = '{
      '{src: SRC_NONE,  cond: COND_ITEM,       alt: UA_BODY, next: UA_NUM},
      '{src: SRC_DIGIT, cond: COND_DIGIT_LOOP, alt: UA_NUM,  next: UA_TAB},
      '{src: SRC_TAB,   cond: COND_NONE,       alt: UA_TAB,  next: UA_BODY},
      '{src: SRC_BODY,  cond: COND_BODY_LOOP,  alt: UA_BODY, next: UA_FETCH}
   };

   typedef struct packed {
      logic       req_valid;
      logic       skip;
      logic       numbered;
      logic       emit_ok;
      logic [1:0] body_last;
   } stat_type;

endpackage

// File: design/tlnef_if.sv
// ----------------------------------------------------------------------------
// tlnef_if
// Valid/ready channels for input bytes and rendered output bytes.
// ----------------------------------------------------------------------------
interface tlnef_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink   (input valid, input char_in, output ready);
endinterface

interface tlnef_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_out;
   logic       run_end;

   modport source (output valid, output char_out, output run_end, input ready);
   modport sink   (input valid, input char_out, input run_end, output ready);
endinterface

// File: design/tlnef_csr.sv
// ----------------------------------------------------------------------------
// tlnef_csr
// APB register file holding the six option bits.
// ----------------------------------------------------------------------------
module tlnef_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [tlnef_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready,
   output tlnef_pkg::cfg_type           cfg
);
   import tlnef_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign reg_idx = paddr[4:2];
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_SQUEEZE_BLANK:    cfg_in.squeeze_blank    = pwdata[0];
            REG_NUMBER_ALL:       cfg_in.number_all       = pwdata[0];
            REG_NUMBER_NONBLANK:  cfg_in.number_nonblank  = pwdata[0];
            REG_SHOW_ENDS:        cfg_in.show_ends        = pwdata[0];
            REG_SHOW_TABS:        cfg_in.show_tabs        = pwdata[0];
            REG_SHOW_NONPRINTING: cfg_in.show_nonprinting = pwdata[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_SQUEEZE_BLANK:    prdata = {31'd0, cfg_ff.squeeze_blank};
         REG_NUMBER_ALL:       prdata = {31'd0, cfg_ff.number_all};
         REG_NUMBER_NONBLANK:  prdata = {31'd0, cfg_ff.number_nonblank};
         REG_SHOW_ENDS:        prdata = {31'd0, cfg_ff.show_ends};
         REG_SHOW_TABS:        prdata = {31'd0, cfg_ff.show_tabs};
         REG_SHOW_NONPRINTING: prdata = {31'd0, cfg_ff.show_nonprinting};
         default:              prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: design/tlnef_seq.sv
// ----------------------------------------------------------------------------
// tlnef_seq
// Microcode sequencer: control store, program counter, loop index and
// conditional branching on datapath status.
// ----------------------------------------------------------------------------
module tlnef_seq #(
   parameter int NUMBER_DIGITS = 6,
   parameter int IDX_W         = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tlnef_pkg::stat_type   stat,
   output tlnef_pkg::ucode_type  ctrl,
   output logic [IDX_W-1:0]      idx
);
   import tlnef_pkg::*;

   localparam logic [IDX_W-1:0] LAST_DIGIT = IDX_W'(NUMBER_DIGITS - 1);

   uaddr_type        upc_ff;
   uaddr_type        upc_in;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   ucode_type        word;

   assign word = UCODE[upc_ff];
   assign ctrl = word;
   assign idx  = idx_ff;

   always_comb begin
      upc_in = upc_ff;
      idx_in = idx_ff;
      unique case (word.cond)
         COND_ITEM: begin
            if (stat.req_valid && !stat.skip) begin
               upc_in = stat.numbered ? word.next : word.alt;
            end
         end
         COND_NONE: begin
            if (stat.emit_ok) begin
               upc_in = word.next;
            end
         end
         COND_DIGIT_LOOP: begin
            if (stat.emit_ok) begin
               if (idx_ff == LAST_DIGIT) begin
                  idx_in = '0;
                  upc_in = word.next;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  upc_in = word.alt;
               end
            end
         end
         COND_BODY_LOOP: begin
            if (stat.emit_ok) begin
               if (idx_ff == IDX_W'(stat.body_last)) begin
                  idx_in = '0;
                  upc_in = word.next;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  upc_in = word.alt;
               end
            end
         end
         default: begin
            upc_in = UA_FETCH;
            idx_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= UA_FETCH;
         idx_ff <= '0;
      end else begin
         upc_ff <= upc_in;
         idx_ff <= idx_in;
      end
   end

endmodule

// File: design/tlnef_dp.sv
// ----------------------------------------------------------------------------
// tlnef_dp
// Datapath: input byte latch, line state, decimal line counter, byte
// rendering and the output register.
// ----------------------------------------------------------------------------
module tlnef_dp #(
   parameter int NUMBER_DIGITS = 6,
   parameter int IDX_W         = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tlnef_pkg::cfg_type   cfg,
   input  tlnef_pkg::ucode_type ctrl,
   input  logic [IDX_W-1:0]     idx,
   output tlnef_pkg::stat_type  stat,
   tlnef_req_if.sink            req_ch,
   tlnef_rsp_if.source          rsp_ch
);
   import tlnef_pkg::*;

   localparam int NUM_BCD = (NUMBER_DIGITS < COUNT_DIGITS) ? NUMBER_DIGITS : COUNT_DIGITS;
   localparam logic [IDX_W:0] LAST_POS  = (IDX_W + 1)'(NUMBER_DIGITS - 1);
   localparam logic [IDX_W:0] BCD_LIMIT = (IDX_W + 1)'(COUNT_DIGITS);

   typedef struct packed {
      logic [1:0]      last;
      logic [3:0][7:0] b;
   } body_type;

   function automatic logic [7:0] caret(input logic [7:0] x);
      return (x == CHR_DEL) ? CHR_QMARK : x + CARET_BIAS;
   endfunction

   function automatic body_type render(input logic [7:0] c, input cfg_type cf);
      body_type   r;
      logic [7:0] low;
      low  = {1'b0, c[6:0]};
      r.b  = {4{c}};
      r.last = 2'd0;
      if (c == CHR_NL) begin
         if (cf.show_ends) begin
            r.b[0] = CHR_DOLLAR;
            r.b[1] = CHR_NL;
            r.last = 2'd1;
         end
      end else if (c == CHR_TAB) begin
         if (cf.show_tabs) begin
            r.b[0] = CHR_CARET;
            r.b[1] = CHR_I;
            r.last = 2'd1;
         end
      end else if (cf.show_nonprinting && (c < CTRL_LIMIT || c == CHR_DEL)) begin
         r.b[0] = CHR_CARET;
         r.b[1] = caret(c);
         r.last = 2'd1;
      end else if (cf.show_nonprinting && c[7]) begin
         r.b[0] = CHR_M;
         r.b[1] = CHR_DASH;
         if (low < CTRL_LIMIT || low == CHR_DEL) begin
            r.b[2] = CHR_CARET;
            r.b[3] = caret(low);
            r.last = 2'd3;
         end else begin
            r.b[2] = low;
            r.last = 2'd2;
         end
      end
      return r;
   endfunction

   logic [7:0]   char_ff;
   logic         at_line_start_ff;
   logic         blank_printed_ff;
   logic         seen_ff;
   logic         seen_in;
   logic [3:0]   bcd_ff  [COUNT_DIGITS];
   logic [3:0]   bcd_inc [COUNT_DIGITS];
   logic         bcd_sat;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   logic [7:0]   char_out_ff;
   logic [7:0]   char_out_in;
   logic         run_end_ff;
   logic         run_end_in;

   logic         is_nl;
   logic         skip;
   logic         numbered;
   logic         accept;
   logic         emit_ok;
   logic         emit;
   body_type     body;
   logic [IDX_W:0] pos;
   logic         pos_ok;
   logic [3:0]   digit;
   logic         digit_blank;
   logic [7:0]   digit_byte;

   assign is_nl    = (req_ch.char_in == CHR_NL);
   assign skip     = cfg.squeeze_blank & at_line_start_ff & is_nl & blank_printed_ff;
   assign numbered = at_line_start_ff &
                     ((cfg.number_all & ~cfg.number_nonblank) | (cfg.number_nonblank & ~is_nl));
   assign req_ch.ready = (ctrl.cond == COND_ITEM);
   assign accept   = req_ch.valid & req_ch.ready;
   assign emit_ok  = ~rsp_valid_ff | rsp_ch.ready;
   assign emit     = (ctrl.src != SRC_NONE) & emit_ok;
   assign body     = render(char_ff, cfg);

   assign stat.req_valid = req_ch.valid;
   assign stat.skip      = skip;
   assign stat.numbered  = numbered;
   assign stat.emit_ok   = emit_ok;
   assign stat.body_last = body.last;

   // saturating decimal increment over the displayed digits
   always_comb begin
      logic carry;
      carry   = 1'b1;
      bcd_sat = 1'b1;
      for (int i = 0; i < COUNT_DIGITS; i++) begin
         bcd_inc[i] = bcd_ff[i];
         if (i < NUM_BCD) begin
            if (bcd_ff[i] != 4'd9) bcd_sat = 1'b0;
            if (carry) begin
               if (bcd_ff[i] == 4'd9) begin
                  bcd_inc[i] = 4'd0;
               end else begin
                  bcd_inc[i] = bcd_ff[i] + 4'd1;
                  carry      = 1'b0;
               end
            end
         end
      end
   end

   assign pos         = LAST_POS - {1'b0, idx};
   assign pos_ok      = (pos < BCD_LIMIT);
   assign digit       = pos_ok ? bcd_ff[pos[2:0]] : 4'd0;
   assign digit_blank = ~seen_ff & (digit == 4'd0) & (pos != '0);
   assign digit_byte  = digit_blank ? CHR_SPACE : (CHR_ZERO | {4'd0, digit});

   always_comb begin
      char_out_in  = char_out_ff;
      run_end_in   = run_end_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      seen_in      = seen_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         run_end_in   = 1'b0;
         unique case (ctrl.src)
            SRC_DIGIT: begin
               char_out_in = digit_byte;
               seen_in     = seen_ff | (digit != 4'd0);
            end
            SRC_TAB:   char_out_in = CHR_TAB;
            SRC_BODY: begin
               char_out_in = body.b[idx[1:0]];
               run_end_in  = (idx[1:0] == body.last);
            end
            default:   char_out_in = char_out_ff;
         endcase
      end
      if (accept) begin
         seen_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      char_out_ff <= char_out_in;
      run_end_ff  <= run_end_in;
      seen_ff     <= seen_in;
      if (accept && !skip) begin
         char_ff <= req_ch.char_in;
      end
      if (reset) begin
         rsp_valid_ff     <= 1'b0;
         at_line_start_ff <= 1'b1;
         blank_printed_ff <= 1'b0;
         for (int i = 0; i < COUNT_DIGITS; i++) bcd_ff[i] <= 4'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept && !skip) begin
            at_line_start_ff <= is_nl;
            blank_printed_ff <= at_line_start_ff & is_nl;
            if (numbered && !bcd_sat) begin
               for (int i = 0; i < COUNT_DIGITS; i++) bcd_ff[i] <= bcd_inc[i];
            end
         end
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.char_out = char_out_ff;
   assign rsp_ch.run_end  = run_end_ff;

endmodule

// File: design/text_line_number_and_escape_filter_core.sv
// ----------------------------------------------------------------------------
// text_line_number_and_escape_filter_core
// Display filter: line numbers, blank-line squeeze, visible ends, tabs and
// control/high bytes, run by a four-step microprogram.
// An input transfer moves the program counter to the number or body step,
// whose emit loads the output register. Each input byte gives 1..11 bytes
// (none if squeezed), one per microstep unless the output stalls.
// Reset: synchronous; clears options, line counter, line state, output valid.
// ----------------------------------------------------------------------------
module text_line_number_and_escape_filter_core #(
   parameter int NUMBER_DIGITS = 6
) (
   input  logic                         clock,
   input  logic                         reset,
   tlnef_req_if.sink                    req_ch,
   tlnef_rsp_if.source                  rsp_ch,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [tlnef_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);
   import tlnef_pkg::*;

   localparam int IDX_W = (NUMBER_DIGITS > 4) ? $clog2(NUMBER_DIGITS) : 2;

   cfg_type          cfg;
   ucode_type        ctrl;
   stat_type         stat;
   logic [IDX_W-1:0] idx;

   tlnef_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tlnef_seq #(
      .NUMBER_DIGITS (NUMBER_DIGITS),
      .IDX_W         (IDX_W)
   ) u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl),
      .idx   (idx)
   );

   tlnef_dp #(
      .NUMBER_DIGITS (NUMBER_DIGITS),
      .IDX_W         (IDX_W)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .ctrl   (ctrl),
      .idx    (idx),
      .stat   (stat),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule

// File: design/tlnef_checker.sv
// ----------------------------------------------------------------------------
// tlnef_checker
// Port-level checks on the filter core, bound to the top level.
// ----------------------------------------------------------------------------
module tlnef_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] char_in,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] char_out,
   input logic       run_end
);
   import tlnef_pkg::*;

   a_reset_clears_out: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("input not ready after reset");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(char_out) && $stable(run_end))
      else $error("stalled output transfer changed");

   a_non_nl_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (char_in != CHR_NL) |=> !req_ready)
      else $error("non-newline transfer produced no output");

   a_ready_after_run: assert property (@(posedge clock) disable iff (reset)
      req_ready && rsp_valid |-> run_end)
      else $error("input taken while a run is incomplete");

endmodule

bind text_line_number_and_escape_filter_core tlnef_checker u_tlnef_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .char_in   (req_ch.char_in),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .char_out  (rsp_ch.char_out),
   .run_end   (rsp_ch.run_end)
);
